// ===== rtl/rrat_pkg.sv =====
package rrat_pkg;

    // Field widths of one transaction and of the stored record.
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned PROC_W   = 8;
    localparam int unsigned HASH_W   = 64;
    localparam int unsigned TS_W     = 48;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned RT_W     = 56;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned RAVG_W   = 64;
    localparam int unsigned CAVG_W   = 48;
    localparam int unsigned NPROC_W  = 9;
    localparam int unsigned FRAC_W   = 8;
    localparam int unsigned SUM_W    = 64;
    localparam int unsigned DVD_W    = SUM_W + FRAC_W;

    // Default sizes, handed to the top level parameters.
    localparam int unsigned ENTRIES_DEF  = 64;
    localparam int unsigned MAX_PROC_DEF = 256;

    // Transaction modes.
    localparam logic [MODE_W-1:0] MODE_ENTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXIT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SHORT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_ENTR = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    // One table record as held in the memory.
    typedef struct packed {
        logic [PROC_W-1:0] proc;
        logic [HASH_W-1:0] hash;
        logic [TS_W-1:0]   start;
        logic [RT_W-1:0]   runtime;
        logic [CNT_W-1:0]  count;
    } t_rec;

endpackage

// ===== rtl/rrat_ram.sv =====
module rrat_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rrat_div.sv =====
module rrat_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rrat_pkg::DVD_W-1:0]    i_dividend,
    input  logic [rrat_pkg::NPROC_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [rrat_pkg::DVD_W-1:0]    o_quotient
);

    import rrat_pkg::*;

    localparam int unsigned CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]   r_q;
    logic [NPROC_W-1:0] r_rem;
    logic [NPROC_W-1:0] r_div;
    logic [CW-1:0]      r_cnt;
    logic               r_run;
    logic               r_done;
    logic [NPROC_W:0]   rem_sh;
    logic               take;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        rem_sh = {r_rem, r_q[DVD_W-1]};
        take   = (rem_sh >= {1'b0, r_div});
    end

    // The dividend register fills up with quotient bits from the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_q   <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
            end else if (r_run) begin
                r_q   <= {r_q[DVD_W-2:0], take};
                r_rem <= take ? NPROC_W'(rem_sh - {1'b0, r_div}) : rem_sh[NPROC_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVD_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

    // A done pulse always closes a run.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_run)) else $error("divider done without a run");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_rem < r_div)) else $error("divider remainder out of range");

endmodule

// ===== rtl/region_runtime_accumulator_table.sv =====
// Channel      Direction  Handshake                 Payload
// command      in         i_start, o_busy           i_mode, i_process_id, i_region_hash,
//                                                   i_timestamp, i_short_time, i_short_count
// result       out        o_valid (one cycle)       o_status, o_runtime_average,
//                                                   o_count_average
// num_process  in         i_num_process_we          i_num_process
//
// A transaction is taken when i_start is high and o_busy is low.
// Every transaction walks the whole table through the record memory read port:
// for entry, exit and short record the walk is followed by one write-back step.
// A query instead runs two passes of the bit-serial divider, one per average.
// Reset clears the valid flags and sets num_process to one; no clearing pass.
// The receiver cannot stall: each result is shown for one cycle only.
module region_runtime_accumulator_table #(
    parameter int unsigned ENTRIES       = rrat_pkg::ENTRIES_DEF,
    parameter int unsigned MAX_PROCESSES = rrat_pkg::MAX_PROC_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [rrat_pkg::MODE_W-1:0]  i_mode,
    input  logic [rrat_pkg::PROC_W-1:0]  i_process_id,
    input  logic [rrat_pkg::HASH_W-1:0]  i_region_hash,
    input  logic [rrat_pkg::TS_W-1:0]    i_timestamp,
    input  logic [rrat_pkg::TS_W-1:0]    i_short_time,
    input  logic [rrat_pkg::CNT_W-1:0]   i_short_count,
    input  logic                         i_num_process_we,
    input  logic [rrat_pkg::NPROC_W-1:0] i_num_process,
    output logic                         o_valid,
    output logic [rrat_pkg::STAT_W-1:0]  o_status,
    output logic [rrat_pkg::RAVG_W-1:0]  o_runtime_average,
    output logic [rrat_pkg::CAVG_W-1:0]  o_count_average
);

    import rrat_pkg::*;

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_APPLY, S_DIV_RT, S_DIV_CNT
    } t_state;

    t_state r_state;

    // Latched command.
    logic [MODE_W-1:0]  r_mode;
    logic [PROC_W-1:0]  r_proc;
    logic [HASH_W-1:0]  r_hash;
    logic [TS_W-1:0]    r_ts;
    logic [TS_W-1:0]    r_stime;
    logic [CNT_W-1:0]   r_scount;
    logic [NPROC_W-1:0] r_nproc;

    // Table walk.
    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0]      r_raddr;
    logic               r_issue;
    logic               r_pend;
    logic [IW-1:0]      r_pidx;
    logic               r_hit;
    logic [IW-1:0]      r_hidx;
    t_rec               r_hrec;
    logic               r_free;
    logic [IW-1:0]      r_fidx;
    logic [SUM_W-1:0]   r_rsum;
    logic [SUM_W-1:0]   r_csum;

    // Result registers.
    logic               r_ovalid;
    logic [STAT_W-1:0]  r_status;
    logic [RAVG_W-1:0]  r_ravg;
    logic [CAVG_W-1:0]  r_cavg;
    logic               r_div_start;

    t_rec               rd_rec;
    t_rec               wr_rec;
    logic               wr_en;
    logic [IW-1:0]      wr_idx;
    logic               rd_vld;
    logic               key_hit;
    logic               hash_hit;
    logic [SUM_W:0]     n_rsum;
    logic [SUM_W:0]     n_csum;
    logic [NPROC_W-1:0] div_val;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;
    logic [DVD_W-1:0]   div_dvd;

    // Record memory; the sequencer never reads and writes in the same pass.
    rrat_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx),
        .i_wdata (wr_rec),
        .i_raddr (r_raddr),
        .o_rdata (rd_rec)
    );

    // Divisor clamped to one and to the process limit; dividend chosen by the division state.
    always_comb begin
        if (r_nproc == '0) begin
            div_val = NPROC_W'(1);
        end else if (32'(r_nproc) > MAX_PROCESSES) begin
            div_val = NPROC_W'(MAX_PROCESSES);
        end else begin
            div_val = r_nproc;
        end
        div_dvd = (r_state == S_DIV_CNT) ? {r_csum, FRAC_W'(0)} : {r_rsum, FRAC_W'(0)};
    end

    rrat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_val),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Matching of the record that the memory returns this cycle.
    always_comb begin
        rd_vld   = r_valid[r_pidx];
        key_hit  = rd_vld && (rd_rec.proc == r_proc) && (rd_rec.hash == r_hash);
        hash_hit = rd_vld && (rd_rec.hash == r_hash);
        n_rsum   = {1'b0, r_rsum} + (SUM_W + 1)'(rd_rec.runtime);
        n_csum   = {1'b0, r_csum} + (SUM_W + 1)'(rd_rec.count);
    end

    // Update of the found or newly allocated record.
    always_comb begin
        t_rec               base;
        logic [TS_W-1:0]    dlt;
        logic [RT_W:0]      rt_sum;
        logic [CNT_W:0]     cnt_sum;
        logic [TS_W-1:0]    add_rt;
        logic [CNT_W-1:0]   add_cnt;

        if (r_hit) begin
            base = r_hrec;
        end else begin
            base = '{proc: r_proc, hash: r_hash, start: '0, runtime: '0, count: '0};
        end
        dlt     = (r_ts > base.start) ? (r_ts - base.start) : '0;
        add_rt  = (r_mode == MODE_EXIT) ? dlt : r_stime;
        add_cnt = (r_mode == MODE_EXIT) ? CNT_W'(1) : r_scount;
        rt_sum  = {1'b0, base.runtime} + (RT_W + 1)'(add_rt);
        cnt_sum = {1'b0, base.count} + (CNT_W + 1)'(add_cnt);

        wr_rec = base;
        if (r_mode == MODE_ENTER) begin
            wr_rec.start = r_ts;
        end else begin
            wr_rec.runtime = (rt_sum >= {1'b0, {RT_W{1'b1}}}) ? {RT_W{1'b1}} : rt_sum[RT_W-1:0];
            wr_rec.count   = (cnt_sum >= {1'b0, {CNT_W{1'b1}}}) ?
                             {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
        end
        wr_idx = r_hit ? r_hidx : r_fidx;
        wr_en  = (r_state == S_APPLY) &&
                 (r_hit || (r_free && (r_mode != MODE_EXIT)));
    end

    // Sequencer: walk, then write back or divide, then report.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_nproc     <= NPROC_W'(1);
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
            r_raddr     <= '0;
        end else begin
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
            if (i_num_process_we) begin
                r_nproc <= i_num_process;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mode   <= i_mode;
                        r_proc   <= i_process_id;
                        r_hash   <= i_region_hash;
                        r_ts     <= i_timestamp;
                        r_stime  <= i_short_time;
                        r_scount <= i_short_count;
                        r_raddr  <= '0;
                        r_issue  <= 1'b1;
                        r_pend   <= 1'b0;
                        r_hit    <= 1'b0;
                        r_free   <= 1'b0;
                        r_rsum   <= '0;
                        r_csum   <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= r_issue;
                    r_pidx <= r_raddr;
                    if (r_issue) begin
                        r_raddr <= r_raddr + 1'b1;
                        if (r_raddr == IW'(ENTRIES - 1)) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_pend) begin
                        if (key_hit && !r_hit) begin
                            r_hit  <= 1'b1;
                            r_hidx <= r_pidx;
                            r_hrec <= rd_rec;
                        end
                        if (!rd_vld && !r_free) begin
                            r_free <= 1'b1;
                            r_fidx <= r_pidx;
                        end
                        if (hash_hit) begin
                            r_rsum <= n_rsum[SUM_W] ? '1 : n_rsum[SUM_W-1:0];
                            r_csum <= n_csum[SUM_W] ? '1 : n_csum[SUM_W-1:0];
                        end
                        if (r_pidx == IW'(ENTRIES - 1)) begin
                            r_pend <= 1'b0;
                            if (r_mode == MODE_QUERY) begin
                                r_div_start <= 1'b1;
                                r_state     <= S_DIV_RT;
                            end else begin
                                r_state <= S_APPLY;
                            end
                        end
                    end
                end
                S_APPLY: begin
                    if (wr_en) begin
                        r_valid[wr_idx] <= 1'b1;
                    end
                    r_ravg   <= '0;
                    r_cavg   <= '0;
                    if (wr_en) begin
                        r_status <= ST_OK;
                    end else if (r_mode == MODE_EXIT) begin
                        r_status <= ST_NO_ENTR;
                    end else begin
                        r_status <= ST_FULL;
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_DIV_RT: begin
                    if (div_done) begin
                        r_ravg      <= (|div_q[DVD_W-1:RAVG_W]) ? '1 : div_q[RAVG_W-1:0];
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_CNT;
                    end
                end
                S_DIV_CNT: begin
                    if (div_done) begin
                        r_cavg   <= (|div_q[DVD_W-1:CAVG_W]) ? '1 : div_q[CAVG_W-1:0];
                        r_status <= ST_OK;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_status          = r_status;
    assign o_runtime_average = r_ravg;
    assign o_count_average   = r_cavg;

    // A result closes a transaction that was in progress.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> $past(r_state != S_IDLE)) else $error("result without transaction");
    // The write-back step always reports on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |=> r_ovalid) else $error("write-back without result");
    // Error results never carry averages.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_status != ST_OK)) |-> ((r_ravg == '0) && (r_cavg == '0)))
        else $error("averages on an error result");
    // Walk data is only processed during the walk.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN)) else $error("walk data outside the walk");

endmodule
